@@ rtl/assert_macros.svh @@
// Assertion helpers included by csr_complex_spmv_row.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SPMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPMV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cspmv_pkg.sv @@
package cspmv_pkg;

  // Default sizes of the stores and the stored value width.
  localparam int MAX_DIM_DEF     = 256;
  localparam int MAX_NNZ_DEF     = 1024;
  localparam int VALUE_WIDTH_DEF = 16;

  // Fixed field widths of the beats.
  localparam int SLOT_W = 10;
  localparam int COL_W  = 8;
  localparam int RS_W   = 11;
  localparam int VAL_W  = 16;
  localparam int ROW_W  = 8;
  localparam int REG_W  = 9;
  localparam int STAT_W = 2;
  localparam int ACC_W  = 48;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  // Configuration register indexes.
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_PTR = 2'd0,
    OP_LOAD_NZ  = 2'd1,
    OP_LOAD_VEC = 2'd2,
    OP_COMPUTE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_ROW = 2'd1,
    STATUS_COL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR0,
    ST_PTR1,
    ST_WALK,
    ST_DONE
  } state_t;

  // Control of the complex multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic vld;
  } cmac_ctrl_t;

endpackage

@@ rtl/cspmv_ram.sv @@
module cspmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cspmv_cmac.sv @@
module cspmv_cmac #(
  parameter int VALUE_WIDTH = cspmv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cspmv_pkg::cmac_ctrl_t               ctrl,
  input  logic signed [VALUE_WIDTH-1:0]       a_re,
  input  logic signed [VALUE_WIDTH-1:0]       a_im,
  input  logic signed [VALUE_WIDTH-1:0]       b_re,
  input  logic signed [VALUE_WIDTH-1:0]       b_im,
  output logic                                busy,
  output logic signed [cspmv_pkg::ACC_W-1:0]  acc_re,
  output logic signed [cspmv_pkg::ACC_W-1:0]  acc_im
);
  import cspmv_pkg::*;

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int TW = PW + 1;
  localparam int SW = ((TW > ACC_W) ? TW : ACC_W) + 1;

  localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SW-1:0]    SMAX = SW'(AMAX);
  localparam logic signed [SW-1:0]    SMIN = SW'(AMIN);

  logic                 v3_r, v4_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [TW-1:0] t_re_r, t_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] acc_re_nxt, acc_im_nxt;
  logic signed [SW-1:0] s_re, s_im;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= ctrl.vld;
      v4_r <= v3_r;
    end
  end

  // Four partial products of the complex multiply.
  always_ff @(posedge clk) begin
    p_rr_r <= a_re * b_re;
    p_ii_r <= a_im * b_im;
    p_ri_r <= a_re * b_im;
    p_ir_r <= a_im * b_re;
  end

  // Combine into the complex term.
  always_ff @(posedge clk) begin
    t_re_r <= TW'(p_rr_r) - TW'(p_ii_r);
    t_im_r <= TW'(p_ri_r) + TW'(p_ir_r);
  end

  // Saturating accumulate to the signed 48-bit range.
  assign s_re = SW'(acc_re_r) + SW'(t_re_r);
  assign s_im = SW'(acc_im_r) + SW'(t_im_r);

  always_comb begin
    priority if (s_re > SMAX) begin
      acc_re_nxt = AMAX;
    end else if (s_re < SMIN) begin
      acc_re_nxt = AMIN;
    end else begin
      acc_re_nxt = s_re[ACC_W-1:0];
    end
    priority if (s_im > SMAX) begin
      acc_im_nxt = AMAX;
    end else if (s_im < SMIN) begin
      acc_im_nxt = AMIN;
    end else begin
      acc_im_nxt = s_im[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v4_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
  end

  assign busy   = v3_r | v4_r;
  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

@@ rtl/csr_complex_spmv_row.sv @@
// Channel   Ports                      Beat contents
// input     in_tvalid/tready/tdata/tuser  one load or compute item
// output    out_tvalid/tready/tdata/tuser one row sum with status
// config    cfg_we/addr/wdata             num_rows, num_cols writes
//
// A load beat writes its store as it is accepted. A compute beat makes
// two row-pointer reads, then one nonzero per cycle through the entry RAM,
// the vector RAM and the complex multiply-accumulate pipeline, then drain.
// The input is not ready while a row is computed; loads are taken while a
// finished result waits on the output register. Reset is synchronous and
// active low; the stores hold no valid bits and need no clearing pass.
`include "assert_macros.svh"

module csr_complex_spmv_row #(
  parameter int MAX_DIM     = cspmv_pkg::MAX_DIM_DEF,
  parameter int MAX_NNZ     = cspmv_pkg::MAX_NNZ_DEF,
  parameter int VALUE_WIDTH = cspmv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input: tdata = slot, col_index, row_start, val_re, val_im, zero pad.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cspmv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Input: tuser = op.
  input  logic [1:0]                        in_tuser,
  // Output: tdata = row, sum_re, sum_im.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cspmv_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Output: tuser = status.
  output logic [cspmv_pkg::STAT_W-1:0]      out_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [cspmv_pkg::REG_W-1:0]       cfg_wdata
);
  import cspmv_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int DIM_W = (REG_W > $clog2(MAX_DIM + 1)) ? REG_W : $clog2(MAX_DIM + 1);
  localparam int CMP_W = (SLOT_W > DIM_W) ? SLOT_W : DIM_W;
  localparam int NZ_W  = (RS_W > $clog2(MAX_NNZ + 1)) ? RS_W : $clog2(MAX_NNZ + 1);
  localparam int EA_W  = $clog2(MAX_NNZ);
  localparam int RP_D  = MAX_DIM + 1;
  localparam int RP_W  = $clog2(RP_D);
  localparam int VA_W  = $clog2(MAX_DIM);
  localparam int EW    = COL_W + 2 * VW;

  state_t state_r, state_nxt;

  logic [REG_W-1:0] num_rows_r, num_cols_r;
  logic [DIM_W-1:0] rows_use, cols_use;

  // Input beat fields.
  op_t              in_op;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  in_col;
  logic [RS_W-1:0]   in_rs;
  logic [VAL_W-1:0]  in_re, in_im;
  logic              accept, start, row_bad;

  // Row walk registers.
  logic [SLOT_W-1:0] slot_r;
  logic [NZ_W-1:0]   first_r, last_r, ptr_r, rp_clamp;
  status_t           status_r;
  logic              v1_r, v2_r, ok2_r;
  logic signed [VW-1:0] ent_re_r, ent_im_r;

  // Memory ports.
  logic            rp_we, ent_we, vec_we;
  logic [RP_W-1:0] rp_waddr, rp_raddr;
  logic [RS_W-1:0] rp_rdata;
  logic [EA_W-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0]   ent_rdata;
  logic [VA_W-1:0] vec_waddr, vec_raddr;
  logic [2*VW-1:0] vec_rdata;
  logic [COL_W-1:0] e_col;

  // Control outputs of the sequencer.
  logic issue, walk_end, out_load;
  cmac_ctrl_t cmac_ctrl;
  logic cmac_busy;
  logic signed [ACC_W-1:0] acc_re, acc_im;

  // Output register.
  logic                 out_tvalid_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [ACC_W-1:0]     out_re_r, out_im_r;
  logic [STAT_W-1:0]    out_stat_r;

  // Unpack the input beat.
  assign in_op   = op_t'(in_tuser);
  assign in_slot = in_tdata[9:0];
  assign in_col  = in_tdata[17:10];
  assign in_rs   = in_tdata[28:18];
  assign in_re   = in_tdata[44:29];
  assign in_im   = in_tdata[60:45];
  assign accept  = in_tvalid && in_tready;
  assign start   = accept && (in_op == OP_COMPUTE);

  // Rows and columns in use are capped at the store size.
  assign rows_use = (DIM_W'(num_rows_r) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : DIM_W'(num_rows_r);
  assign cols_use = (DIM_W'(num_cols_r) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : DIM_W'(num_cols_r);
  assign row_bad  = CMP_W'(in_slot) >= CMP_W'(rows_use);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= REG_W'(256);
      num_cols_r <= REG_W'(256);
    end else if (cfg_we) begin
      if (cfg_addr == REG_NUM_ROWS) begin
        num_rows_r <= cfg_wdata;
      end else begin
        num_cols_r <= cfg_wdata;
      end
    end
  end

  // Load writes, ignored when the slot lies beyond its store.
  always_comb begin
    rp_we  = 1'b0;
    ent_we = 1'b0;
    vec_we = 1'b0;
    if (accept) begin
      unique case (in_op)
        OP_LOAD_PTR: rp_we  = CMP_W'(in_slot) <= CMP_W'(MAX_DIM);
        OP_LOAD_NZ:  ent_we = NZ_W'(in_slot) < NZ_W'(MAX_NNZ);
        OP_LOAD_VEC: vec_we = CMP_W'(in_slot) < CMP_W'(MAX_DIM);
        OP_COMPUTE:  ;
        default:     ;
      endcase
    end
  end

  assign rp_waddr  = RP_W'(in_slot);
  assign ent_waddr = EA_W'(in_slot);
  assign vec_waddr = VA_W'(in_slot);

  cspmv_ram #(.WIDTH(RS_W), .DEPTH(RP_D)) u_rp_ram (
    .clk   (clk),
    .we    (rp_we),
    .waddr (rp_waddr),
    .wdata (in_rs),
    .raddr (rp_raddr),
    .rdata (rp_rdata)
  );

  cspmv_ram #(.WIDTH(EW), .DEPTH(MAX_NNZ)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata ({in_col, VW'(in_im), VW'(in_re)}),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  cspmv_ram #(.WIDTH(2 * VW), .DEPTH(MAX_DIM)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata ({VW'(in_im), VW'(in_re)}),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // Pointers beyond the entry store are clamped to its size.
  assign rp_clamp = (NZ_W'(rp_rdata) > NZ_W'(MAX_NNZ)) ? NZ_W'(MAX_NNZ)
                                                       : NZ_W'(rp_rdata);

  assign issue    = (state_r == ST_WALK) && (ptr_r < last_r);
  assign walk_end = !issue && !v1_r && !v2_r && !cmac_busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = row_bad ? ST_DONE : ST_PTR0;
        end
      end
      ST_PTR0: state_nxt = ST_PTR1;
      ST_PTR1: state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    rp_raddr  = RP_W'(in_slot);
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_PTR0: rp_raddr  = RP_W'(slot_r) + RP_W'(1);
      ST_PTR1: ;
      ST_WALK: ;
      ST_DONE: out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  // Row bounds and walk pointer.
  always_ff @(posedge clk) begin
    if (start) begin
      slot_r <= in_slot;
    end
    if (state_r == ST_PTR0) begin
      first_r <= rp_clamp;
    end
    if (state_r == ST_PTR1) begin
      last_r <= rp_clamp;
      ptr_r  <= first_r;
    end else if (issue) begin
      ptr_r <= ptr_r + NZ_W'(1);
    end
  end

  // Entry read, then vector read at the entry's column.
  assign ent_raddr = ptr_r[EA_W-1:0];
  assign e_col     = ent_rdata[EW-1 -: COL_W];
  assign vec_raddr = VA_W'(e_col);

  always_ff @(posedge clk) begin
    ok2_r    <= CMP_W'(e_col) < CMP_W'(cols_use);
    ent_re_r <= signed'(ent_rdata[VW-1:0]);
    ent_im_r <= signed'(ent_rdata[2*VW-1:VW]);
  end

  // Status: bad row at start, bad column when an entry is skipped.
  always_ff @(posedge clk) begin
    if (start) begin
      status_r <= row_bad ? STATUS_ROW : STATUS_OK;
    end else if (v2_r && !ok2_r) begin
      status_r <= STATUS_COL;
    end
  end

  assign cmac_ctrl.clr = start;
  assign cmac_ctrl.vld = v2_r && ok2_r;

  cspmv_cmac #(.VALUE_WIDTH(VW)) u_cmac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cmac_ctrl),
    .a_re   (ent_re_r),
    .a_im   (ent_im_r),
    .b_re   (signed'(vec_rdata[VW-1:0])),
    .b_im   (signed'(vec_rdata[2*VW-1:VW])),
    .busy   (cmac_busy),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= slot_r[ROW_W-1:0];
      out_re_r   <= acc_re;
      out_im_r   <= acc_im;
      out_stat_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_im_r, out_re_r, out_row_r};
  assign out_tuser  = out_stat_r;

  // A compute beat closes the input until its row is done.
  `SPMV_ASSERT(a_busy_after_start, start |=> !in_tready, "input ready during a row walk")
  // Pipeline reads happen only during the walk.
  `SPMV_ASSERT(a_v1_in_walk, v1_r |-> state_r == ST_WALK, "entry read outside the walk")
  // The end pointer stays clamped while walking.
  `SPMV_ASSERT(a_last_clamped, state_r == ST_WALK |-> last_r <= NZ_W'(MAX_NNZ),
               "end pointer beyond entry store")
  // A bad row reports zero sums.
  `SPMV_ASSERT(a_row_bad_zero, out_tvalid && out_tuser == STATUS_ROW |-> out_tdata[103:8] == '0,
               "nonzero sum on a bad row")
  // No result is pending right after reset.
  `SPMV_ASSERT_RST(a_reset_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule
